[sv/csfs_pkg.sv]
// ----------------------------------------------------------------------------
// csfs_pkg
// Shared constants for the clocked serial frame sampler: register indexes,
// register reset values and the default timer width.
// ----------------------------------------------------------------------------
package csfs_pkg;

   localparam int TIMER_BITS_DEFAULT = 16;

   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_SYNC_GAP      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SETTLE        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_PERIOD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TIMEOUT       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLES       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_WRITE_FRAMES  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_TOTAL_FRAMES  = 3'd6;

   localparam logic [15:0] SYNC_GAP_RESET      = 16'd1800;
   localparam logic [15:0] SETTLE_RESET        = 16'd405;
   localparam logic [15:0] SAMPLE_PERIOD_RESET = 16'd150;
   localparam logic [15:0] TIMEOUT_RESET       = 16'd15000;
   localparam logic [3:0]  SAMPLES_RESET       = 4'd5;
   localparam logic [7:0]  WRITE_FRAMES_RESET  = 8'd64;
   localparam logic [7:0]  TOTAL_FRAMES_RESET  = 8'd128;

endpackage

[sv/clocked_serial_frame_sampler.sv]
// Output: a result word appears at the output register in the cycle after its tick is accepted.
// Throughput: one tick per cycle while the output is not stalled; the state update is a single pass between
// the state registers and the output register.
// Reset: synchronous, active high; clears the state, loads the register
// defaults and empties the output register.
// ----------------------------------------------------------------------------
// clocked_serial_frame_sampler
// Per-tick sync detection, settle/sample timer and LSB-first frame packing,
// with timeout reporting on expiry outside a sampled frame.
// ----------------------------------------------------------------------------
module clocked_serial_frame_sampler
   import csfs_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_clock_rise,
   input  logic                   req_data_level,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_frame_bits,
   output logic [7:0]             rsp_frame_index,
   output logic                   rsp_last_frame,
   output logic                   rsp_timeout_flag,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

   logic [15:0] sync_gap_ff, settle_ff, period_ff, timeout_ff;
   logic [3:0]  samples_ff;
   logic [7:0]  write_frames_ff, total_frames_ff;

   logic                  synced_ff, synced_in;
   logic                  sampling_ff, sampling_in;
   logic                  timed_out_ff, timed_out_in;
   logic                  running_ff, running_in;
   logic [7:0]            frame_count_ff, frame_count_in;
   logic [7:0]            word_ff, word_in;
   logic [3:0]            sample_count_ff, sample_count_in;
   logic [TIMER_BITS-1:0] count_ff, count_in;
   logic [TIMER_BITS-1:0] compare_ff, compare_in;

   logic       rsp_valid_ff;
   logic [7:0] bits_ff, bits_in;
   logic [7:0] index_ff, index_in;
   logic       last_ff, last_in;
   logic       tflag_ff;
   logic       emit;
   logic       accept;

   function automatic logic [TIMER_BITS-1:0] to_timer(input logic [15:0] v);
      logic [CW-1:0] ext;
      ext = CW'(v);
      return ext[TIMER_BITS-1:0];
   endfunction

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      synced_in       = synced_ff;
      sampling_in     = sampling_ff;
      timed_out_in    = timed_out_ff;
      running_in      = running_ff;
      frame_count_in  = frame_count_ff;
      word_in         = word_ff;
      sample_count_in = sample_count_ff;
      count_in        = count_ff;
      compare_in      = compare_ff;
      emit            = 1'b0;
      bits_in         = 8'd0;
      index_in        = 8'd0;
      last_in         = 1'b0;

      // advance the timer, handle expiry
      if (running_ff) begin
         count_in = count_ff + TIMER_BITS'(1);
         if (count_in >= compare_ff) begin
            count_in = '0;
            if (!synced_ff || !sampling_ff) begin
               running_in   = 1'b0;
               timed_out_in = 1'b1;
               emit         = 1'b1;
            end else begin
               timed_out_in = 1'b0;
               if (frame_count_ff < write_frames_ff) begin
                  if (sample_count_ff == 4'd0) begin
                     compare_in = to_timer(period_ff);
                     running_in = 1'b1;
                  end
                  if (req_data_level && !sample_count_ff[3])
                     word_in[sample_count_ff[2:0]] = 1'b1;
                  sample_count_in = sample_count_ff + 4'd1;
                  if (sample_count_in >= samples_ff) begin
                     emit           = 1'b1;
                     bits_in        = word_in;
                     index_in       = frame_count_ff;
                     frame_count_in = frame_count_ff + 8'd1;
                     last_in        = frame_count_in >= write_frames_ff;
                     sampling_in    = 1'b0;
                     count_in       = '0;
                     compare_in     = to_timer(timeout_ff);
                     running_in     = 1'b1;
                  end
               end else begin
                  frame_count_in = frame_count_ff + 8'd1;
                  if (frame_count_in >= total_frames_ff)
                     synced_in = 1'b0;
                  sampling_in = 1'b0;
                  compare_in  = to_timer(timeout_ff);
                  running_in  = 1'b1;
               end
            end
         end
      end

      // handle the bus clock edge
      if (req_clock_rise && !sampling_in) begin
         if (!synced_in && (CW'(count_in) < CW'(sync_gap_ff))) begin
            count_in   = '0;
            compare_in = to_timer(timeout_ff);
            running_in = 1'b1;
         end else begin
            if (!synced_in) begin
               synced_in      = 1'b1;
               frame_count_in = 8'd0;
            end
            word_in         = 8'd0;
            sample_count_in = 4'd0;
            sampling_in     = 1'b1;
            count_in        = '0;
            compare_in      = to_timer(settle_ff);
            running_in      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_gap_ff     <= SYNC_GAP_RESET;
         settle_ff       <= SETTLE_RESET;
         period_ff       <= SAMPLE_PERIOD_RESET;
         timeout_ff      <= TIMEOUT_RESET;
         samples_ff      <= SAMPLES_RESET;
         write_frames_ff <= WRITE_FRAMES_RESET;
         total_frames_ff <= TOTAL_FRAMES_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_SYNC_GAP:      sync_gap_ff     <= csr_write_data;
            REG_SETTLE:        settle_ff       <= csr_write_data;
            REG_SAMPLE_PERIOD: period_ff       <= csr_write_data;
            REG_TIMEOUT:       timeout_ff      <= csr_write_data;
            REG_SAMPLES:       samples_ff      <= csr_write_data[3:0];
            REG_WRITE_FRAMES:  write_frames_ff <= csr_write_data[7:0];
            REG_TOTAL_FRAMES:  total_frames_ff <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         synced_ff       <= 1'b0;
         sampling_ff     <= 1'b0;
         timed_out_ff    <= 1'b0;
         running_ff      <= 1'b0;
         frame_count_ff  <= 8'd0;
         word_ff         <= 8'd0;
         sample_count_ff <= 4'd0;
         count_ff        <= '0;
         compare_ff      <= to_timer(TIMEOUT_RESET);
      end else if (accept) begin
         synced_ff       <= synced_in;
         sampling_ff     <= sampling_in;
         timed_out_ff    <= timed_out_in;
         running_ff      <= running_in;
         frame_count_ff  <= frame_count_in;
         word_ff         <= word_in;
         sample_count_ff <= sample_count_in;
         count_ff        <= count_in;
         compare_ff      <= compare_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= accept && emit;
      end
   end

   // hold the word while the consumer stalls
   always_ff @(posedge clock) begin
      if (accept && emit && req_ready) begin
         bits_ff  <= bits_in;
         index_ff <= index_in;
         last_ff  <= last_in;
         tflag_ff <= timed_out_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_bits   = bits_ff;
   assign rsp_frame_index  = index_ff;
   assign rsp_last_frame   = last_ff;
   assign rsp_timeout_flag = tflag_ff;

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds timebase ticks into the serial frame sampler, predicts the sync,
// settle, sample and timeout behavior tick by tick, and checks every frame
// and timeout word against that prediction under random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
   import csfs_pkg::*;

   localparam int ITEM_TARGET    = 1700;
   localparam int LONG_HOLD      = 120;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic [7:0] frame_bits;
      logic [7:0] frame_index;
      logic       last_frame;
      logic       timeout_flag;
   } frame_word_type;

   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic                   req_clock_rise   = 1'b0;
   logic                   req_data_level   = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic [7:0]             rsp_frame_bits;
   logic [7:0]             rsp_frame_index;
   logic                   rsp_last_frame;
   logic                   rsp_timeout_flag;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;

   // register copies
   logic [15:0] cfg_sync_gap, cfg_settle, cfg_period, cfg_timeout;
   logic [3:0]  cfg_samples;
   logic [7:0]  cfg_write_frames, cfg_total_frames;

   // sampler state copies
   logic        st_synced, st_sampling, st_timed_out, st_timer_on;
   logic [7:0]  st_frame_count, st_word;
   logic [3:0]  st_sample_count;
   logic [15:0] st_timer_count, st_timer_cmp;

   frame_word_type pending_frames[$];
   int             mismatch_count = 0;
   int             ticks_sent     = 0;
   int             stall_cycles   = 0;
   int             holds_asked    = 0;
   int             holds_done     = 0;
   bit             idling_on      = 1'b1;

   clocked_serial_frame_sampler dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_clock_rise   (req_clock_rise),
      .req_data_level   (req_data_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_bits   (rsp_frame_bits),
      .rsp_frame_index  (rsp_frame_index),
      .rsp_last_frame   (rsp_last_frame),
      .rsp_timeout_flag (rsp_timeout_flag),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void reset_sampler_model();
      cfg_sync_gap     = SYNC_GAP_RESET;
      cfg_settle       = SETTLE_RESET;
      cfg_period       = SAMPLE_PERIOD_RESET;
      cfg_timeout      = TIMEOUT_RESET;
      cfg_samples      = SAMPLES_RESET;
      cfg_write_frames = WRITE_FRAMES_RESET;
      cfg_total_frames = TOTAL_FRAMES_RESET;
      st_synced        = 1'b0;
      st_sampling      = 1'b0;
      st_timed_out     = 1'b0;
      st_timer_on      = 1'b0;
      st_frame_count   = '0;
      st_word          = '0;
      st_sample_count  = '0;
      st_timer_count   = '0;
      st_timer_cmp     = TIMEOUT_RESET;
   endfunction

   function automatic void restart_timer(input logic [15:0] cmp);
      st_timer_count = '0;
      st_timer_cmp   = cmp;
      st_timer_on    = 1'b1;
   endfunction

   function automatic void write_sampler_reg(input logic [CSR_INDEX_W-1:0] idx,
                                             input logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_SYNC_GAP:      cfg_sync_gap     = value;
         REG_SETTLE:        cfg_settle       = value;
         REG_SAMPLE_PERIOD: cfg_period       = value;
         REG_TIMEOUT:       cfg_timeout      = value;
         REG_SAMPLES:       cfg_samples      = value[3:0];
         REG_WRITE_FRAMES:  cfg_write_frames = value[7:0];
         REG_TOTAL_FRAMES:  cfg_total_frames = value[7:0];
         default: ;
      endcase
   endfunction

   // advance the timer, handle its expiry, then the bus clock edge
   function automatic bit sample_tick(input logic rise, input logic level,
                                      output frame_word_type word);
      bit made;
      made = 1'b0;
      word = '0;
      if (st_timer_on) begin
         st_timer_count = st_timer_count + 16'd1;
         if (st_timer_count >= st_timer_cmp) begin
            st_timer_count = '0;
            if (!st_synced || !st_sampling) begin
               st_timer_on       = 1'b0;
               st_timed_out      = 1'b1;
               word.timeout_flag = 1'b1;
               made              = 1'b1;
            end else begin
               st_timed_out = 1'b0;
               if (st_frame_count < cfg_write_frames) begin
                  if (st_sample_count == 4'd0)
                     restart_timer(cfg_period);
                  if (level && st_sample_count < 4'd8)
                     st_word[st_sample_count[2:0]] = 1'b1;
                  st_sample_count = st_sample_count + 4'd1;
                  if (st_sample_count >= cfg_samples) begin
                     word.frame_bits  = st_word;
                     word.frame_index = st_frame_count;
                     st_frame_count   = st_frame_count + 8'd1;
                     word.last_frame  = st_frame_count >= cfg_write_frames;
                     st_sampling      = 1'b0;
                     restart_timer(cfg_timeout);
                     made             = 1'b1;
                  end
               end else begin
                  st_frame_count = st_frame_count + 8'd1;
                  if (st_frame_count >= cfg_total_frames)
                     st_synced = 1'b0;
                  st_sampling = 1'b0;
                  restart_timer(cfg_timeout);
               end
            end
         end
      end
      if (rise && !st_sampling) begin
         if (!st_synced && st_timer_count < cfg_sync_gap) begin
            restart_timer(cfg_timeout);
         end else begin
            if (!st_synced) begin
               st_synced      = 1'b1;
               st_frame_count = '0;
            end
            st_word         = '0;
            st_sample_count = '0;
            st_sampling     = 1'b1;
            restart_timer(cfg_settle);
         end
      end
      if (made)
         word.timeout_flag = st_timed_out;
      return made;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : frame_check
      frame_word_type want;
      frame_word_type next;
      bit             made;
      if (reset) begin
         reset_sampler_model();
         pending_frames.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_frames.size() == 0) begin
               report_mismatch($sformatf("unexpected word bits=%02h idx=%0d last=%0b to=%0b",
                  rsp_frame_bits, rsp_frame_index, rsp_last_frame, rsp_timeout_flag));
            end else begin
               want = pending_frames.pop_front();
               if (rsp_frame_bits !== want.frame_bits)
                  report_mismatch($sformatf("frame_bits %02h, want %02h",
                     rsp_frame_bits, want.frame_bits));
               if (rsp_frame_index !== want.frame_index)
                  report_mismatch($sformatf("frame_index %0d, want %0d",
                     rsp_frame_index, want.frame_index));
               if (rsp_last_frame !== want.last_frame)
                  report_mismatch($sformatf("last_frame %0b, want %0b",
                     rsp_last_frame, want.last_frame));
               if (rsp_timeout_flag !== want.timeout_flag)
                  report_mismatch($sformatf("timeout_flag %0b, want %0b",
                     rsp_timeout_flag, want.timeout_flag));
            end
         end
         if (csr_write_enable)
            write_sampler_reg(csr_index, csr_write_data);
         if (req_valid && req_ready) begin
            made = sample_tick(req_clock_rise, req_data_level, next);
            if (made)
               pending_frames.push_back(next);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : result_sink
      forever begin
         @(posedge clock);
         if (holds_done != holds_asked) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            holds_done++;
         end else begin
            rsp_ready <= !(idling_on && $urandom_range(0, 99) < 13);
         end
      end
   end

   task automatic send_tick(input logic rise, input logic level);
      if (idling_on && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_clock_rise <= rise;
      req_data_level <= level;
      do @(posedge clock); while (!req_ready);
      ticks_sent++;
   endtask

   task automatic quiet(input int count);
      repeat (count) send_tick(1'b0, 1'($urandom_range(0, 1)));
   endtask

   task automatic noise(input int count, input int edge_pct);
      repeat (count) send_tick($urandom_range(0, 99) < edge_pct, 1'($urandom_range(0, 1)));
   endtask

   // drop valid and wait until every predicted word has been taken
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_frames.size() != 0 || rsp_valid) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   task automatic apply_setup(input logic [15:0] sync_gap, input logic [15:0] settle,
                              input logic [15:0] period, input logic [15:0] timeout,
                              input logic [15:0] samples, input logic [15:0] write_frames,
                              input logic [15:0] total_frames);
      quiesce();
      write_reg(REG_SYNC_GAP, sync_gap);
      write_reg(REG_SETTLE, settle);
      write_reg(REG_SAMPLE_PERIOD, period);
      write_reg(REG_TIMEOUT, timeout);
      write_reg(REG_SAMPLES, samples);
      write_reg(REG_WRITE_FRAMES, write_frames);
      write_reg(REG_TOTAL_FRAMES, total_frames);
      write_reg(REG_UNUSED, CSR_DATA_W'($urandom));
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // one bus clock: edge tick, then the settle and sample ticks
   task automatic run_frame();
      int span;
      span = int'(cfg_settle) + int'(cfg_period) *
             ((cfg_samples == 4'd0) ? 0 : int'(cfg_samples) - 1);
      send_tick(1'b1, 1'($urandom_range(0, 1)));
      for (int i = 0; i < span; i++)
         send_tick(i < span - 1 && $urandom_range(0, 99) < 8, 1'($urandom_range(0, 1)));
   endtask

   // arm, idle for the sync gap or half of it, then clock a whole frame cycle
   task automatic run_cycle(input int extra);
      send_tick(1'b1, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 99) < 15)
         quiet(int'(cfg_sync_gap) / 2);
      else
         quiet(int'(cfg_sync_gap) + $urandom_range(0, 2));
      repeat (int'(cfg_total_frames) + extra) begin
         run_frame();
         if ($urandom_range(0, 99) < 10)
            quiet(int'(cfg_timeout) + 2);
         else
            quiet($urandom_range(0, 2));
      end
   endtask

   task automatic test_directed_window();
      apply_setup(16'd2, 16'd1, 16'd1, 16'd6, 16'd4, 16'd2, 16'd3);
      send_tick(1'b1, 1'b0);
      quiet(2);
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b1);
      repeat (3) send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      quiet(7);
   endtask

   task automatic test_register_extremes();
      apply_setup(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      noise(30, 30);
      apply_setup(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd2);
      noise(40, 40);
      apply_setup(16'd1, 16'd1, 16'd1, 16'd2, 16'd1, 16'd1, 16'd2);
      noise(40, 40);
   endtask

   task automatic test_sample_counts();
      apply_setup(16'd3, 16'd2, 16'd1, 16'd12, 16'd0, 16'd4, 16'd6);
      run_cycle(1);
      apply_setup(16'd3, 16'd1, 16'd2, 16'd40, 16'd15, 16'd3, 16'd4);
      run_cycle(1);
      apply_setup(16'd3, 16'd1, 16'd1, 16'd20, 16'd8, 16'd3, 16'd4);
      run_cycle(0);
   endtask

   task automatic test_full_window();
      idling_on = 1'b0;
      apply_setup(16'd3, 16'd1, 16'd1, 16'd8, 16'd1, 16'd255, 16'd255);
      run_cycle(3);
      quiesce();
      idling_on = 1'b1;
   endtask

   task automatic test_backpressure();
      apply_setup(16'd4, 16'd2, 16'd1, 16'd20, 16'd3, 16'd6, 16'd8);
      holds_asked++;
      run_cycle(0);
      run_cycle(1);
   endtask

   task automatic test_random_cycles();
      logic [15:0] junk;
      logic [15:0] sync_gap;
      logic [3:0]  samples;
      logic [7:0]  write_frames, total_frames;
      int          phases;
      phases = 0;
      while (ticks_sent < ITEM_TARGET || phases < 3) begin
         junk         = 16'($urandom);
         sync_gap     = 16'($urandom_range(1, 12));
         samples      = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 8))
                                                     : 4'($urandom_range(0, 15));
         write_frames = 8'($urandom_range(1, 8));
         total_frames = ($urandom_range(0, 99) < 80)
                        ? write_frames + 8'($urandom_range(1, 4))
                        : 8'($urandom_range(2, 9));
         apply_setup(sync_gap, 16'($urandom_range(1, 6)), 16'($urandom_range(1, 4)),
                     sync_gap + 16'd3 + 16'($urandom_range(0, 20)),
                     {junk[15:4], samples}, {junk[15:8], write_frames},
                     {junk[7:0], total_frames});
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 99) < 10)
               noise(25, 30);
            else
               run_cycle($urandom_range(0, 2));
         end
         phases++;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_window();
      test_register_extremes();
      test_sample_counts();
      test_full_window();
      test_backpressure();
      test_random_cycles();
      quiesce();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
